FILE: rtl/rpn_stack_evaluator_macros.svh
// Assertion macros shared by the RPN stack evaluator RTL.
// Defining ASSERT_OFF turns every assertion into an empty statement.
// No dependencies.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever ante holds, cons holds too.
`define RPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpn assertion failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpn assertion failed");
`else
`define RPN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the RPN stack evaluator: token and status
// codes, controller-to-datapath command and status structs, saturation helper.
// No dependencies.
package rpn_pkg;

	localparam int DATA_W = 32;

	// Token codes on the mode field.
	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_MUL  = 3'd3;
	localparam logic [2:0] MODE_DIV  = 3'd4;
	localparam logic [2:0] MODE_END  = 3'd5;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_NOT_ONE   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;

	// Operator select, the mode code minus one.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Dividend is the 32-bit magnitude shifted up by 16, one quotient bit per step.
	localparam int DIV_STEPS = 48;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int MAG_W     = DIV_STEPS;

	typedef struct packed {
		logic       push;
		logic       set_err;
		logic [2:0] err;
		logic       mul_load;
		logic       div_load;
		logic       div_step;
		logic       wb;
		logic [1:0] op;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic lt2;
		logic top_zero;
		logic err_set;
		logic div_last;
		logic out_free;
	} sts_t;

	// Apply a sign to an unsigned magnitude and clamp it to the 32-bit signed range.
	function automatic logic [DATA_W-1:0] sat_mag(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic big;
		big = |mag[MAG_W-1:DATA_W-1];
		if (big) begin
			sat_mag = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else if (neg) begin
			sat_mag = {DATA_W{1'b0}} - mag[DATA_W-1:0];
		end else begin
			sat_mag = mag[DATA_W-1:0];
		end
	endfunction

endpackage

FILE: rtl/rpn_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/rpn_dp.sv
`timescale 1ns / 1ps
// Datapath of the RPN stack evaluator: top-of-stack register, stack RAM,
// adder, multiplier, radix-2 divider and output register. Uses rpn_pkg, rpn_ram.
`include "rpn_stack_evaluator_macros.svh"
module rpn_dp
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [DATA_W-1:0] operand,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [DATA_W-1:0] value
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [DATA_W-1:0] top_q;
	logic [CW-1:0]     count_q;
	logic [2:0]        err_q;
	logic              sign_q;
	logic [MAG_W-1:0]  prod_q;
	logic [DATA_W-1:0] rem_q;
	logic [MAG_W-1:0]  quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [DATA_W-1:0] value_q;

	logic [DATA_W-1:0]   left;
	logic [DATA_W-1:0]   mag_l;
	logic [DATA_W-1:0]   mag_r;
	logic [2*DATA_W-1:0] product;
	logic [DATA_W:0]     sum;
	logic [DATA_W:0]     diff;
	logic [DATA_W-1:0]   res;
	logic [DATA_W:0]     rem_sh;
	logic                ge;
	logic                ram_we;
	logic [CW-1:0]       count_m1;
	logic [CW-1:0]       count_m2;
	logic [2:0]          end_status;
	logic [DATA_W-1:0]   end_value;

	assign count_m1 = count_q - CW'(1);
	assign count_m2 = count_q - CW'(2);
	assign ram_we   = cmd.push && (count_q != '0);

	// Entries below the top live in the RAM; the top stays in top_q.
	rpn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_m1[AW-1:0]),
		.wdata(top_q),
		.raddr(count_m2[AW-1:0]),
		.rdata(left)
	);

	always_comb begin
		mag_l   = left[DATA_W-1] ? ({DATA_W{1'b0}} - left) : left;
		mag_r   = top_q[DATA_W-1] ? ({DATA_W{1'b0}} - top_q) : top_q;
		product = mag_l * mag_r;
		sum     = {left[DATA_W-1], left} + {top_q[DATA_W-1], top_q};
		diff    = {left[DATA_W-1], left} - {top_q[DATA_W-1], top_q};
		rem_sh  = {rem_q, quo_q[MAG_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
	end

	always_comb begin
		case (cmd.op)
			OP_ADD: begin
				if (sum[DATA_W] != sum[DATA_W-1]) begin
					res = sat_mag({MAG_W{1'b1}}, sum[DATA_W]);
				end else begin
					res = sum[DATA_W-1:0];
				end
			end
			OP_SUB: begin
				if (diff[DATA_W] != diff[DATA_W-1]) begin
					res = sat_mag({MAG_W{1'b1}}, diff[DATA_W]);
				end else begin
					res = diff[DATA_W-1:0];
				end
			end
			OP_MUL: res = sat_mag(prod_q, sign_q);
			OP_DIV: res = sat_mag(quo_q, sign_q);
			default: res = top_q;
		endcase
	end

	always_comb begin
		if (err_q != ST_OK) begin
			end_status = err_q;
			end_value  = '0;
		end else if (count_q == CW'(1)) begin
			end_status = ST_OK;
			end_value  = top_q;
		end else begin
			end_status = ST_NOT_ONE;
			end_value  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.wb) begin
				count_q <= count_m1;
			end else if (cmd.finish) begin
				count_q <= '0;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err;
			end else if (cmd.finish) begin
				err_q <= ST_OK;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= operand;
		end else if (cmd.wb) begin
			top_q <= res;
		end
		if (cmd.mul_load || cmd.div_load) begin
			sign_q <= left[DATA_W-1] ^ top_q[DATA_W-1];
		end
		if (cmd.mul_load) begin
			prod_q <= product[2*DATA_W-1:16];
		end
		if (cmd.div_load) begin
			rem_q  <= '0;
			quo_q  <= {mag_l, 16'd0};
			dvs_q  <= mag_r;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? DATA_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DATA_W-1:0];
			quo_q  <= {quo_q[MAG_W-2:0], ge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.finish) begin
			status_q <= end_status;
			value_q  <= end_value;
		end
	end

	assign sts.full     = count_q == CW'(STACK_DEPTH);
	assign sts.lt2      = count_q < CW'(2);
	assign sts.top_zero = top_q == '0;
	assign sts.err_set  = err_q != ST_OK;
	assign sts.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;

	`RPN_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(STACK_DEPTH))
	`RPN_ASSERT_IMP(a_wb_two_entries, clk, arst_n, cmd.wb, count_q >= CW'(2))
	`RPN_ASSERT_IMP(a_div_nonzero, clk, arst_n, cmd.div_step, dvs_q != '0)
	`RPN_ASSERT_NEXT(a_end_clears, clk, arst_n, cmd.finish, (count_q == '0) && (err_q == ST_OK))
	`RPN_ASSERT_NEXT(a_end_valid, clk, arst_n, cmd.finish, out_valid_q)

endmodule

FILE: rtl/rpn_ctrl.sv
`timescale 1ns / 1ps
// Controller of the RPN stack evaluator: decodes tokens and sequences the
// datapath through read, multiply, divide and end steps. Uses rpn_pkg.
`include "rpn_stack_evaluator_macros.svh"
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DIVWB = 3'd4;
	localparam logic [2:0] S_END   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] op_q;
	logic       accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.op  = op_q;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_END: state_d = S_END;
						MODE_PUSH: begin
							if (!sts.err_set) begin
								if (sts.full) begin
									cmd.set_err = 1'b1;
									cmd.err     = ST_OVERFLOW;
								end else begin
									cmd.push = 1'b1;
								end
							end
						end
						MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
							if (!sts.err_set) begin
								if (sts.lt2) begin
									cmd.set_err = 1'b1;
									cmd.err     = ST_UNDERFLOW;
								end else if (mode == MODE_DIV && sts.top_zero) begin
									cmd.set_err = 1'b1;
									cmd.err     = ST_DIVZERO;
								end else begin
									state_d = S_READ;
								end
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_READ: begin
				case (op_q)
					OP_MUL: begin
						cmd.mul_load = 1'b1;
						state_d      = S_MUL;
					end
					OP_DIV: begin
						cmd.div_load = 1'b1;
						state_d      = S_DIV;
					end
					default: begin
						cmd.wb  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_MUL: begin
				cmd.wb  = 1'b1;
				state_d = S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_DIVWB;
				end
			end
			S_DIVWB: begin
				cmd.wb  = 1'b1;
				state_d = S_IDLE;
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= 2'(mode - MODE_ADD);
			end
		end
	end

	`RPN_ASSERT_IMP(a_finish_free, clk, arst_n, cmd.finish, sts.out_free)
	`RPN_ASSERT_IMP(a_push_room, clk, arst_n, cmd.push, !sts.full && !sts.err_set)
	`RPN_ASSERT_NEXT(a_div_to_wb, clk, arst_n, (state_q == S_DIV) && sts.div_last, state_q == S_DIVWB)

endmodule

FILE: rtl/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// Top level of the RPN stack evaluator: controller plus datapath.
// Uses rpn_pkg, rpn_ctrl, rpn_dp (which holds rpn_ram).
//
//   channel  handshake            payload
//   input    in_valid / in_stall   mode[2:0], operand[31:0] (signed Q16.16)
//   output   out_valid / out_stall status[2:0], value[31:0] (signed Q16.16)
//
// Token steps: push, ignored tokens and error-raising tokens finish in idle;
// add and subtract go through a read step; multiply through read and multiply;
// divide through read, the radix-2 divider that retires one of 48 quotient bits
// per cycle, and write-back; end waits in its end step while the output is stalled.
// Reset clears the stack count, the latched error and the output valid flag;
// the stack RAM is not cleared, as only entries below the count are ever read.
// A finished result sits in its own output register, so tokens keep flowing
// while it waits; only a second end token waits for the first result to leave.
module rpn_stack_evaluator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic [DATA_W-1:0] operand,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [DATA_W-1:0] value
);

	// Commands flow from the controller to the datapath, flags flow back.
	cmd_t cmd;
	sts_t sts;

	// The controller decodes each token against the stack flags and steps the
	// datapath through multi-cycle operators; it holds in_stall while busy.
	rpn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode    (mode),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath keeps the top of stack in a register and the deeper entries
	// in a RAM, so an operator needs just one RAM read for its left operand.
	rpn_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.operand  (operand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.value    (value)
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_evaluator: a scoreboard class that
// evaluates each accepted token and checks every result, plus stimulus tasks.
// Depends on rpn_pkg and the rpn_stack_evaluator RTL.
import rpn_pkg::*;

localparam int EVAL_DEPTH = 16;

localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;

// Codes the block must ignore.
localparam logic [2:0] MODE_SPARE6 = 3'd6;
localparam logic [2:0] MODE_SPARE7 = 3'd7;

typedef struct packed {
	logic [2:0]        status;
	logic [DATA_W-1:0] value;
} expr_result_t;

class expr_scoreboard;
	logic signed [DATA_W-1:0] operands[EVAL_DEPTH];
	int unsigned              live;
	logic [2:0]               latched_err;
	expr_result_t             pending[$];
	int unsigned              mismatches;

	function new();
		live = 0;
		latched_err = ST_OK;
		mismatches = 0;
	endfunction

	function int outstanding();
		return pending.size();
	endfunction

	function longint unsigned magnitude(logic signed [DATA_W-1:0] v);
		longint wide;
		wide = v;
		return (wide < 0) ? -wide : wide;
	endfunction

	// Signs a magnitude and clamps it into the Q16.16 range.
	function logic [DATA_W-1:0] clamp_signed(longint unsigned mag, bit neg);
		if (neg) begin
			if (mag >= 64'h8000_0000) return Q_MIN;
			return DATA_W'(64'd0 - mag);
		end
		if (mag > 64'h7FFF_FFFF) return Q_MAX;
		return DATA_W'(mag);
	endfunction

	function logic [DATA_W-1:0] clamp_sum(longint s);
		if (s > 64'sd2147483647) return Q_MAX;
		if (s < -64'sd2147483648) return Q_MIN;
		return DATA_W'(s);
	endfunction

	// Applies one accepted token to the predicted stack and, for an end
	// token, queues the result the block has to produce.
	function void note_token(logic [2:0] code, logic [DATA_W-1:0] payload);
		logic signed [DATA_W-1:0] lhs, rhs;
		logic [DATA_W-1:0]        res;
		expr_result_t             outcome;
		bit                       neg;
		if (code == MODE_END) begin
			outcome.status = latched_err;
			outcome.value = '0;
			if (latched_err == ST_OK) begin
				if (live == 1) outcome.value = operands[0];
				else outcome.status = ST_NOT_ONE;
			end
			pending.push_back(outcome);
			live = 0;
			latched_err = ST_OK;
			return;
		end
		if (code > MODE_END || latched_err != ST_OK) return;
		if (code == MODE_PUSH) begin
			if (live >= EVAL_DEPTH) begin
				latched_err = ST_OVERFLOW;
			end else begin
				operands[live] = payload;
				live++;
			end
			return;
		end
		if (live < 2) begin
			latched_err = ST_UNDERFLOW;
			return;
		end
		lhs = operands[live-2];
		rhs = operands[live-1];
		neg = lhs[DATA_W-1] ^ rhs[DATA_W-1];
		case (code)
			MODE_ADD: res = clamp_sum(longint'(lhs) + longint'(rhs));
			MODE_SUB: res = clamp_sum(longint'(lhs) - longint'(rhs));
			MODE_MUL: res = clamp_signed((magnitude(lhs) * magnitude(rhs)) >> 16, neg);
			default: begin
				if (rhs == 0) begin
					latched_err = ST_DIVZERO;
					return;
				end
				res = clamp_signed((magnitude(lhs) << 16) / magnitude(rhs), neg);
			end
		endcase
		live--;
		operands[live-1] = res;
	endfunction

	function void check_result(logic [2:0] status, logic [DATA_W-1:0] value);
		expr_result_t want;
		if (pending.size() == 0) begin
			$error("unexpected result: status %0d value %h", status, value);
			mismatches++;
			return;
		end
		want = pending.pop_front();
		if (status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, status);
			mismatches++;
		end
		if (value !== want.value) begin
			$error("value: expected %h, actual %h", want.value, value);
			mismatches++;
		end
	endfunction
endclass

module tb;

	localparam int TOKEN_TARGET = 1350;

	// Operator codes, picked at random for operator tokens.
	localparam logic [2:0] OPERATORS[4] = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

	// Corner values of the Q16.16 range.
	localparam logic [DATA_W-1:0] EXTREME_Q[6] =
		'{Q_MAX, Q_MIN, Q_ONE, Q_NEG_ONE, 32'hFFFF_FFFF, 32'h0000_0001};

	// Every block input starts at a known value; reset is held from time zero.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        mode = MODE_PUSH;
	logic [DATA_W-1:0] operand = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [2:0]        status;
	logic [DATA_W-1:0] value;

	expr_scoreboard sb;
	int unsigned    tokens_sent = 0;
	bit             sender_steady = 1'b0;
	bit             drained_once = 1'b0;
	int unsigned    pick;

	rpn_stack_evaluator #(
		.STACK_DEPTH(EVAL_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.operand  (operand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.value    (value)
	);

	always #5 clk = ~clk;

	// Both monitors sample at the rising edge, before any nonblocking update
	// of that edge lands, so they see exactly what the block saw. A token
	// transfer feeds the predictor; a result transfer is checked against the
	// oldest prediction.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_token(mode, operand);
		if (arst_n && out_valid && !out_stall) sb.check_result(status, value);
	end

	// Idle lengths: mostly none or short, now and then a long one. A steady
	// stretch runs with no idling at all.
	function automatic int idle_len(bit steady);
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Numbers to push: full-range noise, small values with fractions,
	// range corners and zero, which also serves as a divisor.
	function automatic logic [DATA_W-1:0] random_q();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5, 6: return DATA_W'((int'($urandom_range(0, 16)) - 8) * 65536
				+ int'($urandom_range(0, 65535)));
			7: return EXTREME_Q[$urandom_range(0, 5)];
			8: return '0;
			default: return DATA_W'(int'($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	// Offers one token after a random gap and holds it until the transfer.
	// The stall seen right after the edge is the one the block sampled.
	task automatic send_token(input logic [2:0] code, input logic [DATA_W-1:0] payload);
		int gap;
		gap = idle_len(sender_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= code;
		operand <= payload;
		do @(posedge clk); while (in_stall);
		if (code <= MODE_END) tokens_sent++;
	endtask

	// A well-formed expression with random numbers and operators. Most are
	// short; some hold a full stack's worth of numbers, pushed all up front
	// when greedy. Ignored codes are sprinkled in now and then.
	task automatic send_expression();
		int left, live;
		bit greedy;
		left = ($urandom_range(0, 7) == 0) ? EVAL_DEPTH : $urandom_range(1, 6);
		live = 0;
		greedy = ($urandom_range(0, 2) == 0);
		while (left > 0 || live > 1) begin
			if ($urandom_range(0, 39) == 0)
				send_token($urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7, $urandom());
			if (left > 0 && (live < 2 || greedy || $urandom_range(0, 1) == 1)) begin
				send_token(MODE_PUSH, random_q());
				left--;
				live++;
			end else begin
				send_token(OPERATORS[$urandom_range(0, 3)], $urandom());
				live--;
			end
		end
		send_token(MODE_END, $urandom());
	endtask

	// Arbitrary codes in arbitrary order, closed by an end token; this is
	// where underflow and latched errors mostly come from.
	task automatic send_noise();
		repeat ($urandom_range(1, 8)) send_token(3'($urandom_range(0, 7)), random_q());
		send_token(MODE_END, $urandom());
	endtask

	// Fills the stack to the brim or past it, then folds part of it back.
	// Exactly a full stack followed by enough operators gives a valid result.
	task automatic send_overflow();
		repeat (EVAL_DEPTH + $urandom_range(0, 2)) send_token(MODE_PUSH, random_q());
		repeat ($urandom_range(0, EVAL_DEPTH)) send_token(OPERATORS[$urandom_range(0, 3)],
			$urandom());
		send_token(MODE_END, $urandom());
	endtask

	// Directed opening: saturation at both ends, divide by zero, underflow
	// with a latched error swallowing a later push, an empty end, two
	// entries left at the end, and the two ignored codes.
	task automatic run_directed();
		send_token(MODE_PUSH, Q_MAX);
		send_token(MODE_PUSH, Q_ONE);
		send_token(MODE_ADD, '0);
		send_token(MODE_END, '0);

		send_token(MODE_PUSH, Q_MIN);
		send_token(MODE_PUSH, Q_ONE);
		send_token(MODE_SUB, '1);
		send_token(MODE_END, '1);

		send_token(MODE_PUSH, Q_MIN);
		send_token(MODE_PUSH, Q_MIN);
		send_token(MODE_MUL, '0);
		send_token(MODE_END, '0);

		send_token(MODE_PUSH, Q_ONE);
		send_token(MODE_PUSH, '0);
		send_token(MODE_DIV, '1);
		send_token(MODE_END, '0);

		send_token(MODE_MUL, '0);
		send_token(MODE_PUSH, Q_ONE);
		send_token(MODE_END, '0);

		send_token(MODE_END, '1);

		send_token(MODE_PUSH, 32'hFFFE_8000);
		send_token(MODE_SPARE6, '1);
		send_token(MODE_SPARE7, '0);
		send_token(MODE_PUSH, 32'h0003_0000);
		send_token(MODE_END, '0);
	endtask

	// Result side. Ready and stall stretches alternate at random. Once the
	// run is under way the receiver holds off for a long stretch while the
	// sender keeps offering tokens, so a finished result parks in the output
	// register and the next end token backs up into the input.
	initial begin : result_sink
		int unsigned rx_cycles;
		int          ready_len, stall_len;
		bit          held;
		rx_cycles = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && rx_cycles >= 2000) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				rx_cycles += 400;
				held = 1'b1;
			end
			ready_len = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
			out_stall <= 1'b0;
			repeat (ready_len) @(posedge clk);
			stall_len = idle_len(1'b0);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			rx_cycles += ready_len + stall_len;
		end
	end

	// Token side and end of run.
	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		while (tokens_sent < TOKEN_TARGET) begin
			// Halfway through, the sender goes quiet until every result
			// it is owed has been transferred.
			if (!drained_once && tokens_sent >= TOKEN_TARGET / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.outstanding() != 0) @(posedge clk);
				drained_once = 1'b1;
			end
			sender_steady = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 75) send_expression();
			else if (pick < 95) send_noise();
			else send_overflow();
		end
		in_valid <= 1'b0;

		// Wait out the last results, then give a stray extra result time
		// to show up; a divide is the longest token.
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
